// ===== rtl/tkec_pkg.sv =====
// Package for the two-key event classifier: count width, event codes,
// pairing modes and the per-key state record. No dependencies.
`default_nettype none

package tkec_pkg;

    localparam int COUNT_BITS = 17;
    localparam int TICK_BITS  = 16;
    localparam int CFG_BITS   = 2;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
    localparam logic [TICK_BITS-1:0]  WAIT_MAX  = {TICK_BITS{1'b1}};

    typedef enum logic [2:0] {
        EV_NONE        = 3'd0,
        EV_BOTH        = 3'd1,
        EV_LEFT_LONG   = 3'd2,
        EV_LEFT_CLICK  = 3'd3,
        EV_RIGHT_LONG  = 3'd4,
        EV_RIGHT_CLICK = 3'd5
    } t_key_event;

    typedef enum logic [2:0] {
        MODE_IDLE     = 3'b001,
        MODE_DEBOUNCE = 3'b010,
        MODE_RELEASE  = 3'b100
    } t_pair_mode;

    typedef enum logic [CFG_BITS-1:0] {
        REG_DEBOUNCE   = 2'd0,
        REG_LONG_PRESS = 2'd1
    } t_cfg_index;

    typedef struct packed {
        logic                  held;
        logic                  long_done;
        logic [COUNT_BITS-1:0] elapsed;
    } t_key_state;

    typedef struct packed {
        logic long_fire;
        logic click_fire;
    } t_key_flags;

endpackage

`default_nettype wire

// ===== rtl/tkec_key_unit.sv =====
// Per-key press tracker: takes the ticked key state and the level for this
// transaction, gives the next state and the long-press and click flags. Uses tkec_pkg.
`default_nettype none

module tkec_key_unit (
    input  var tkec_pkg::t_key_state         i_state,
    input  wire                              i_pressed,
    input  wire [tkec_pkg::TICK_BITS-1:0]    i_debounce_ticks,
    input  wire [tkec_pkg::TICK_BITS-1:0]    i_long_press_ticks,
    output tkec_pkg::t_key_state             o_state,
    output tkec_pkg::t_key_flags             o_flags
);
    import tkec_pkg::*;

    logic [COUNT_BITS-1:0] long_ext;
    logic [COUNT_BITS-1:0] deb_ext;

    assign long_ext = COUNT_BITS'(i_long_press_ticks);
    assign deb_ext  = COUNT_BITS'(i_debounce_ticks);

    always_comb begin
        o_state = i_state;
        o_flags = '0;
        if (i_pressed) begin
            if (!i_state.held) begin
                o_state.held      = 1'b1;
                o_state.elapsed   = '0;
                o_state.long_done = 1'b0;
            end else if (!i_state.long_done && (i_state.elapsed > long_ext)) begin
                o_state.long_done = 1'b1;
                o_flags.long_fire = 1'b1;
            end
        end else if (i_state.held) begin
            o_state.held = 1'b0;
            o_flags.click_fire = !i_state.long_done && (i_state.elapsed > deb_ext);
        end
    end

endmodule

`default_nettype wire

// ===== rtl/two_key_event_classifier_unit.sv =====
// Top level of the two-key event classifier: pairing mode control, per-key
// trackers, configuration registers and a two-entry output buffer. Uses tkec_pkg, tkec_key_unit.
`default_nettype none

// One tick sample is taken per cycle unless input is stalled, and its event
// code is registered in the output buffer; the sustained rate is one transaction
// per clock while the output is not stalled. The whole tick is evaluated in a
// single pass of logic from the state registers to the output buffer, which
// holds up to two codes, so input is stalled only when both entries are full.
// Configuration is always ready; indexes beyond the two registers are ignored.

module two_key_event_classifier_unit (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_in_valid,
    output logic                           o_in_stall,
    input  wire                            i_left_down,
    input  wire                            i_right_down,
    output logic                           o_out_valid,
    input  wire                            i_out_stall,
    output logic [2:0]                     o_key_event,
    input  wire                            i_cfg_valid,
    output logic                           o_cfg_ready,
    input  wire [tkec_pkg::CFG_BITS-1:0]   i_cfg_index,
    input  wire [tkec_pkg::TICK_BITS-1:0]  i_cfg_data
);
    import tkec_pkg::*;

    logic [TICK_BITS-1:0] r_debounce_ticks;
    logic [TICK_BITS-1:0] r_long_press_ticks;
    t_pair_mode           r_mode, n_mode;
    logic [TICK_BITS-1:0] r_wait, n_wait;
    t_key_state           r_left, n_left;
    t_key_state           r_right, n_right;
    logic                 r_out_valid;
    t_key_event           r_out_event;
    logic                 r_skid_valid;
    t_key_event           r_skid_event;

    t_key_state           left_tick, right_tick;
    t_key_state           left_upd, right_upd;
    t_key_flags           left_flags, right_flags;
    logic                 keys_go;
    logic                 key_l, key_r;
    logic                 both_down;
    logic [TICK_BITS-1:0] wait_inc;
    t_key_event           ev;
    logic                 in_acc;
    logic                 out_take;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = r_skid_valid;
    assign o_out_valid = r_out_valid;
    assign o_key_event = r_out_event;
    assign in_acc      = i_in_valid && !r_skid_valid;
    assign out_take    = r_out_valid && !i_out_stall;
    assign both_down   = i_left_down && i_right_down;

    always_comb begin
        left_tick  = r_left;
        right_tick = r_right;
        if (r_left.held && (r_left.elapsed != COUNT_MAX)) begin
            left_tick.elapsed = r_left.elapsed + 1'b1;
        end
        if (r_right.held && (r_right.elapsed != COUNT_MAX)) begin
            right_tick.elapsed = r_right.elapsed + 1'b1;
        end
    end

    tkec_key_unit u_left (
        .i_state            (left_tick),
        .i_pressed          (key_l),
        .i_debounce_ticks   (r_debounce_ticks),
        .i_long_press_ticks (r_long_press_ticks),
        .o_state            (left_upd),
        .o_flags            (left_flags)
    );

    tkec_key_unit u_right (
        .i_state            (right_tick),
        .i_pressed          (key_r),
        .i_debounce_ticks   (r_debounce_ticks),
        .i_long_press_ticks (r_long_press_ticks),
        .o_state            (right_upd),
        .o_flags            (right_flags)
    );

    assign wait_inc = (r_wait != WAIT_MAX) ? r_wait + 1'b1 : r_wait;

    always_comb begin
        n_mode  = r_mode;
        n_wait  = r_wait;
        keys_go = 1'b0;
        key_l   = i_left_down;
        key_r   = i_right_down;
        ev      = EV_NONE;
        unique case (r_mode)
            MODE_DEBOUNCE: begin
                n_wait = wait_inc;
                if (wait_inc >= r_debounce_ticks) begin
                    if (both_down) begin
                        n_mode = MODE_RELEASE;
                    end else begin
                        n_mode  = MODE_IDLE;
                        keys_go = 1'b1;
                        key_l   = 1'b1;
                        key_r   = 1'b1;
                    end
                end
            end
            MODE_RELEASE: begin
                if (!both_down) begin
                    n_mode = MODE_IDLE;
                    ev     = EV_BOTH;
                end
            end
            default: begin
                n_mode = MODE_IDLE;
                if (both_down) begin
                    n_mode = MODE_DEBOUNCE;
                    n_wait = '0;
                end else begin
                    keys_go = 1'b1;
                end
            end
        endcase

        n_left  = left_tick;
        n_right = right_tick;
        if (keys_go) begin
            n_left = left_upd;
            priority if (left_flags.long_fire) begin
                ev = EV_LEFT_LONG;
            end else if (left_flags.click_fire) begin
                ev = EV_LEFT_CLICK;
            end else begin
                n_right = right_upd;
                priority if (right_flags.long_fire) begin
                    ev = EV_RIGHT_LONG;
                end else if (right_flags.click_fire) begin
                    ev = EV_RIGHT_CLICK;
                end else begin
                    ev = EV_NONE;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce_ticks   <= 16'd20;
            r_long_press_ticks <= 16'd1000;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == REG_DEBOUNCE) begin
                r_debounce_ticks <= i_cfg_data;
            end
            if (i_cfg_index == REG_LONG_PRESS) begin
                r_long_press_ticks <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_IDLE;
            r_wait  <= '0;
            r_left  <= '0;
            r_right <= '0;
        end else if (in_acc) begin
            r_mode  <= n_mode;
            r_wait  <= n_wait;
            r_left  <= n_left;
            r_right <= n_right;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (out_take) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end
        end else if (!r_out_valid || out_take) begin
            r_out_valid <= in_acc;
        end else if (in_acc) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (out_take) begin
                r_out_event <= r_skid_event;
            end
        end else if (!r_out_valid || out_take) begin
            r_out_event <= ev;
        end else if (in_acc) begin
            r_skid_event <= ev;
        end
    end

endmodule

`default_nettype wire

// ===== tb/tb_two_key_event_classifier_unit.sv =====
// Testbench for two_key_event_classifier_unit: random and directed key-level ticks,
// a behavioural predictor of the event codes and an in-order check of every result.
// Depends on tkec_pkg and the RTL of the block only.
`timescale 1ns / 1ps

module tb_two_key_event_classifier_unit;

    import tkec_pkg::*;

    localparam int          LEFT         = 0;
    localparam int          RIGHT        = 1;
    localparam int unsigned HOLD_CYCLES  = 400;
    localparam int unsigned QUIET_LIMIT  = 3000;
    localparam longint      TIMEOUT_NS   = 64'd50_000_000;
    localparam logic [CFG_BITS-1:0] REG_SPARE_LO = 2'd2;
    localparam logic [CFG_BITS-1:0] REG_SPARE_HI = 2'd3;

    typedef struct packed {
        logic left;
        logic right;
    } t_levels;

    logic                 i_clk        = 1'b0;
    logic                 i_rst_n      = 1'b0;
    logic                 i_in_valid   = 1'b0;
    logic                 i_left_down  = 1'b0;
    logic                 i_right_down = 1'b0;
    logic                 i_out_stall  = 1'b0;
    logic                 i_cfg_valid  = 1'b0;
    logic [CFG_BITS-1:0]  i_cfg_index  = '0;
    logic [TICK_BITS-1:0] i_cfg_data   = '0;
    logic                 o_in_stall;
    logic                 o_out_valid;
    logic [2:0]           o_key_event;
    logic                 o_cfg_ready;

    two_key_event_classifier_unit i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_left_down  (i_left_down),
        .i_right_down (i_right_down),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_key_event  (o_key_event),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    // Predictor state and configuration
    logic [TICK_BITS-1:0]  settle_ticks = 16'd20;
    logic [TICK_BITS-1:0]  hold_limit   = 16'd1000;
    t_pair_mode            pair_state   = MODE_IDLE;
    logic [TICK_BITS-1:0]  pair_count   = '0;
    bit                    key_held      [2];
    bit                    key_long_done [2];
    logic [COUNT_BITS-1:0] key_elapsed   [2];

    t_levels     tick_queue[$];
    t_key_event  event_queue[$];
    t_levels     next_tick;
    t_key_event  due_event;
    bit          in_taken     = 1'b0;
    bit          hold_req     = 1'b0;
    int unsigned send_idle_pct = 0;
    int unsigned stall_pct     = 0;
    int unsigned events_seen   = 0;
    int unsigned error_count   = 0;

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t ns: %s", $time, what);
        error_count++;
    endtask

    function automatic t_key_event key_track(input int side, input bit pressed);
        t_key_event ev;
        ev = EV_NONE;
        if (pressed) begin
            if (!key_held[side]) begin
                key_held[side]      = 1'b1;
                key_elapsed[side]   = '0;
                key_long_done[side] = 1'b0;
            end else if (!key_long_done[side] && key_elapsed[side] > hold_limit) begin
                key_long_done[side] = 1'b1;
                ev = (side == LEFT) ? EV_LEFT_LONG : EV_RIGHT_LONG;
            end
        end else if (key_held[side]) begin
            key_held[side] = 1'b0;
            if (!key_long_done[side] && key_elapsed[side] > settle_ticks)
                ev = (side == LEFT) ? EV_LEFT_CLICK : EV_RIGHT_CLICK;
        end
        return ev;
    endfunction

    function automatic t_key_event keys_track(input bit l, input bit r);
        t_key_event ev;
        ev = key_track(LEFT, l);
        if (ev == EV_NONE)
            ev = key_track(RIGHT, r);
        return ev;
    endfunction

    function automatic t_key_event classify_tick(input bit l, input bit r);
        t_key_event ev;
        int         s;
        ev = EV_NONE;
        for (s = 0; s < 2; s++) begin
            if (key_held[s] && key_elapsed[s] != COUNT_MAX)
                key_elapsed[s] = key_elapsed[s] + 1'b1;
        end
        case (pair_state)
            MODE_DEBOUNCE: begin
                if (pair_count != WAIT_MAX)
                    pair_count = pair_count + 1'b1;
                if (pair_count >= settle_ticks) begin
                    if (l && r) begin
                        pair_state = MODE_RELEASE;
                    end else begin
                        pair_state = MODE_IDLE;
                        ev = keys_track(1'b1, 1'b1);
                    end
                end
            end
            MODE_RELEASE: begin
                if (!(l && r)) begin
                    pair_state = MODE_IDLE;
                    ev = EV_BOTH;
                end
            end
            default: begin
                pair_state = MODE_IDLE;
                if (l && r) begin
                    pair_state = MODE_DEBOUNCE;
                    pair_count = '0;
                end else begin
                    ev = keys_track(l, r);
                end
            end
        endcase
        return ev;
    endfunction

    // Driver
    always @(negedge i_clk) begin
        if (i_rst_n && (!i_in_valid || in_taken)) begin
            if (tick_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                next_tick = tick_queue.pop_front();
                i_in_valid   <= 1'b1;
                i_left_down  <= next_tick.left;
                i_right_down <= next_tick.right;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        if (hold_req)
            i_out_stall <= 1'b1;
        else
            i_out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    // Hold the output back for a long stretch
    always begin
        wait (hold_req);
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_req = 1'b0;
    end

    // Monitor
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            in_taken = i_in_valid && !o_in_stall;
            if (in_taken)
                event_queue.push_back(classify_tick(i_left_down, i_right_down));
            if (o_out_valid && !i_out_stall) begin
                events_seen++;
                if (event_queue.size() == 0) begin
                    report_mismatch($sformatf("key_event %0d with no transaction due",
                                              o_key_event));
                end else begin
                    due_event = event_queue.pop_front();
                    if (o_key_event !== due_event)
                        report_mismatch($sformatf("key_event %0d, expected %0d (%s)",
                                                  o_key_event, due_event, due_event.name()));
                end
            end
        end else begin
            in_taken = 1'b0;
        end
    end

    task automatic write_reg(input logic [CFG_BITS-1:0] idx, input logic [TICK_BITS-1:0] value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            REG_DEBOUNCE:   settle_ticks = value;
            REG_LONG_PRESS: hold_limit   = value;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic push_levels(input bit l, input bit r, input int unsigned count);
        t_levels lv;
        lv.left  = l;
        lv.right = r;
        repeat (count) tick_queue.push_back(lv);
    endtask

    function automatic int unsigned pick_hold();
        case ($urandom_range(0, 3))
            0:       return $urandom_range(1, 3);
            1:       return settle_ticks + $urandom_range(0, 3);
            2:       return hold_limit + $urandom_range(0, 4);
            default: return $urandom_range(1, hold_limit + 6);
        endcase
    endfunction

    task automatic push_episode();
        int unsigned kind, la, lb, oa, ob, span, t;
        bit          side;
        t_levels     lv;
        kind = $urandom_range(0, 9);
        side = 1'($urandom_range(0, 1));
        if (kind < 2) begin
            repeat ($urandom_range(1, 6)) begin
                lv.left  = 1'($urandom_range(0, 1));
                lv.right = 1'($urandom_range(0, 1));
                tick_queue.push_back(lv);
            end
        end else if (kind < 5) begin
            push_levels(!side, side, pick_hold());
            push_levels(1'b0, 1'b0, $urandom_range(1, 3));
        end else if (kind < 7) begin
            oa = $urandom_range(0, 3);
            la = pick_hold();
            ob = $urandom_range(0, 6);
            lb = pick_hold();
            span = ((oa + la > ob + lb) ? oa + la : ob + lb) + 1;
            for (t = 0; t < span; t++) begin
                lv.left  = (t >= oa) && (t < oa + la);
                lv.right = (t >= ob) && (t < ob + lb);
                tick_queue.push_back(lv);
            end
        end else begin
            push_levels(1'b1, 1'b1, pick_hold());
            push_levels(!side, side, $urandom_range(0, 4));
            push_levels(1'b0, 1'b0, $urandom_range(1, 3));
        end
    endtask

    task automatic drain();
        int unsigned quiet, last_seen;
        quiet     = 0;
        last_seen = events_seen;
        while ((tick_queue.size() != 0 || i_in_valid || event_queue.size() != 0)
               && quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if (events_seen != last_seen) begin
                last_seen = events_seen;
                quiet     = 0;
            end else begin
                quiet++;
            end
        end
        while (event_queue.size() != 0)
            report_mismatch($sformatf("transaction never returned, expected %0d",
                                      event_queue.pop_front()));
        tick_queue.delete();
        repeat (4) @(posedge i_clk);
    endtask

    task automatic run_random(input logic [TICK_BITS-1:0] settle, input logic [TICK_BITS-1:0] hold,
                              input int unsigned idle, input int unsigned stall,
                              input int unsigned items, input bit with_hold);
        write_reg(REG_DEBOUNCE, settle);
        write_reg(REG_LONG_PRESS, hold);
        @(posedge i_clk);
        send_idle_pct = idle;
        stall_pct     = stall;
        while (tick_queue.size() < items) push_episode();
        if (with_hold) begin
            @(posedge i_clk);
            hold_req = 1'b1;
        end
        drain();
    endtask

    initial begin
        key_held      = '{1'b0, 1'b0};
        key_long_done = '{1'b0, 1'b0};
        key_elapsed   = '{'0, '0};
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: a click just past the debounce period
        push_levels(1'b1, 1'b0, 25);
        push_levels(1'b0, 1'b0, 1);
        drain();

        // Directed: clicks, long presses, pair press, failed second sample,
        // left event masking the right key
        write_reg(REG_DEBOUNCE, 16'd1);
        write_reg(REG_LONG_PRESS, 16'd2);
        push_levels(1'b0, 1'b0, 1);
        push_levels(1'b1, 1'b0, 3);
        push_levels(1'b0, 1'b0, 1);
        push_levels(1'b0, 1'b1, 5);
        push_levels(1'b0, 1'b0, 1);
        push_levels(1'b1, 1'b1, 3);
        push_levels(1'b0, 1'b1, 1);
        push_levels(1'b1, 1'b1, 1);
        push_levels(1'b1, 1'b0, 1);
        push_levels(1'b0, 1'b0, 1);
        push_levels(1'b1, 1'b0, 3);
        push_levels(1'b1, 1'b1, 1);
        push_levels(1'b0, 1'b1, 2);
        push_levels(1'b0, 1'b0, 1);
        drain();

        run_random(16'd3, 16'd10, 0, 0, 310, 1'b1);
        run_random(16'd2, 16'd6, 58, 0, 310, 1'b0);
        run_random(16'd5, 16'd20, 0, 58, 310, 1'b0);
        run_random(16'd0, 16'd0, 13, 13, 310, 1'b0);
        write_reg(REG_SPARE_LO, 16'hFFFF);
        write_reg(REG_SPARE_HI, 16'h0000);
        run_random(16'd1, 16'd1, 0, 0, 310, 1'b0);
        run_random(16'd20, 16'd60, 0, 0, 310, 1'b0);

        if (error_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("status: fail");
        $finish;
    end

endmodule

// ===== two_key_event_classifier_unit.f =====
rtl/tkec_pkg.sv
rtl/tkec_key_unit.sv
rtl/two_key_event_classifier_unit.sv
tb/tb_two_key_event_classifier_unit.sv
